FILE: design/b32e_pkg.sv
// Shared types, constants and helpers for the Base32 encoder.
package b32e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [6:0] CHAR_A   = 7'h41;
	localparam logic [6:0] CHAR_TWO = 7'h32;
	localparam logic [6:0] CHAR_PAD = 7'h3D;
	localparam logic [4:0] NUM_LETTERS = 5'd26;
	localparam logic [3:0] GROUP_BITS  = 4'd5;
	localparam logic [3:0] TWO_GROUPS  = 4'd10;
	localparam logic [3:0] BYTE_BITS   = 4'd8;

	// One byte's worth of work: up to three symbol indexes (data, data, flush),
	// how many of them are used, and the total character count incl. padding.
	typedef struct packed {
		logic [2:0][4:0] idx;
		logic [1:0]      nsym;
		logic [3:0]      ntot;
		logic            last;
	} job_t;

	function automatic logic [6:0] alpha(input logic [4:0] idx);
		logic [6:0] ch;
		if (idx < NUM_LETTERS) begin
			ch = CHAR_A + {2'b00, idx};
		end else begin
			ch = CHAR_TWO + {2'b00, idx - NUM_LETTERS};
		end
		return ch;
	endfunction

endpackage

FILE: design/b32e_front.sv
// Front end: accepts bytes, tracks pending bits and character phase, builds jobs.
module b32e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              q_full,
	output logic              q_push,
	output b32e_pkg::job_t    q_job
);

	logic [2:0]  held_q;
	logic [3:0]  store_q;
	logic [2:0]  phase_q;

	logic [3:0]  held_new;
	logic [11:0] win;
	logic        two;
	logic [2:0]  hr;
	logic [3:0]  rem;
	logic [4:0]  idx0;
	logic [4:0]  idx1;
	logic [4:0]  idx2;
	logic [1:0]  k;
	logic        flush;
	logic [1:0]  nsym;
	logic [2:0]  psum;
	logic [2:0]  pad;
	logic        acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign q_push   = acc;

	always_comb begin
		held_new = {1'b0, held_q} + b32e_pkg::BYTE_BITS;
		win      = {store_q, in_byte};
		two      = held_new >= b32e_pkg::TWO_GROUPS;
		idx0     = 5'(win >> (held_new - b32e_pkg::GROUP_BITS));
		idx1     = two ? 5'(win >> (held_new - b32e_pkg::TWO_GROUPS)) : 5'd0;
		hr       = two ? 3'(held_new - b32e_pkg::TWO_GROUPS)
		               : 3'(held_new - b32e_pkg::GROUP_BITS);
		rem      = win[3:0] & 4'((5'd1 << hr) - 5'd1);
		idx2     = 5'({1'b0, rem} << (3'd5 - hr));
		k        = two ? 2'd2 : 2'd1;
		flush    = in_last && (hr != 3'd0);
		nsym     = k + {1'b0, flush};
		psum     = phase_q + {1'b0, nsym};
		pad      = in_last ? 3'(3'd0 - psum) : 3'd0;
		// data chars first, flush goes into the slot right after them
		q_job.idx[0] = idx0;
		q_job.idx[1] = two ? idx1 : idx2;
		q_job.idx[2] = idx2;
		q_job.nsym   = nsym;
		q_job.ntot   = {2'b00, nsym} + {1'b0, pad};
		q_job.last   = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			store_q <= '0;
			phase_q <= '0;
		end else if (acc) begin
			if (in_last) begin
				held_q  <= '0;
				store_q <= '0;
				phase_q <= '0;
			end else begin
				held_q  <= hr;
				store_q <= rem;
				phase_q <= phase_q + {1'b0, k};
			end
		end
	end

`ifndef ASSERT_OFF
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= 3'd4)
		else $error("pending bit count out of range");
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |=> held_q == 3'd0 && phase_q == 3'd0 && store_q == 4'd0)
		else $error("state not cleared after last byte");
	a_last_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |-> 3'(phase_q + 3'(q_job.ntot)) == 3'd0)
		else $error("padded message not a multiple of eight characters");
`endif

endmodule

FILE: design/b32e_fifo.sv
// Short job queue between the front end and the character sequencer.
module b32e_fifo #(
	parameter int unsigned DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b32e_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output b32e_pkg::job_t rd_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	b32e_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

FILE: design/b32e_back.sv
// Back end: walks each job one character per cycle, while the output is not stalled, into the output register.
module b32e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  b32e_pkg::job_t job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [6:0]     out_char,
	output logic           out_last
);

	logic [2:0] step_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic       fire;
	logic       end_step;
	logic [4:0] sym;
	logic [6:0] ch;

	assign fire     = job_valid && (!valid_q || out_ready);
	assign end_step = step_q == 3'(job.ntot - 4'd1);
	assign job_pop  = fire && end_step;

	always_comb begin
		case (step_q)
			3'd0:    sym = job.idx[0];
			3'd1:    sym = job.idx[1];
			3'd2:    sym = job.idx[2];
			default: sym = '0;
		endcase
		ch = (step_q < {1'b0, job.nsym}) ? b32e_pkg::alpha(sym) : b32e_pkg::CHAR_PAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else if (fire) begin
			step_q  <= end_step ? 3'd0 : step_q + 3'd1;
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q <= ch;
			last_q <= job.last && end_step;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

FILE: design/base32_encoder_padded.sv
// Top level of the padded Base32 byte-to-character encoder.
// Bytes arrive on the slave stream, tlast marking a message's final byte;
// Base32 characters (A-Z, 2-7, '=') leave on the master stream, tlast on the
// final character of the message. For each accepted byte the front end works
// out the one or two 5-bit groups it completes, the flush group and the '='
// padding count on a last byte, and queues that as one job. The back end
// sends one character per cycle, while the output is not stalled, from the
// queue head into an output register. A byte yields 1 or 2 characters as a
// plain byte, up to 8 as a last byte, about 1.6 per byte on a long message.
// The character sequencer's one-per-cycle output port sets that rate; the
// QUEUE_DEPTH-entry job queue lets both sides stall independently. A byte's
// job is registered in the queue, and each of its characters is registered in
// the output register before it is valid on the master stream.
module base32_encoder_padded #(
	parameter int unsigned QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic       m_tlast    // out_last
);

	b32e_pkg::job_t push_job;
	b32e_pkg::job_t head_job;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_not_empty;
	logic [6:0]     out_char;

	// front end: per-byte bit bookkeeping
	b32e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	// decoupling queue
	b32e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_job    (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_job    (head_job)
	);

	// back end: one character transaction per cycle unless stalled
	b32e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (head_job),
		.job_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule
